// ===== src/pixel_format_converter_palette_defines.svh =====
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_PALETTE_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_PALETTE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PFCP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PFCP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel format converter package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcp_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CH_W                = 8;
    localparam int TAG_IDX_W           = 8;
    localparam int SQ_W                = 16;
    localparam int DIST_W              = 23;
    localparam int PIX_W               = 24;
    localparam int BYTES_W             = 2;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 3;
    localparam int S_TDATA_W           = 32;
    localparam int M_TDATA_W           = 32;

    localparam logic [DIST_W-1:0] W_RED   = DIST_W'(28);
    localparam logic [DIST_W-1:0] W_GREEN = DIST_W'(91);
    localparam logic [DIST_W-1:0] W_BLUE  = DIST_W'(9);
    localparam logic [PIX_W-1:0]  TOP_BIT = PIX_W'(24'h008000);

    typedef enum logic [2:0] {
        MODE_R5G5B5X1 = 3'd0,
        MODE_X1B5G5R5 = 3'd1,
        MODE_RED      = 3'd2,
        MODE_B2G3R3   = 3'd3,
        MODE_RGB24    = 3'd4,
        MODE_PALETTE  = 3'd5
    } mode_t;

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_WRITE   = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_MODE = 1'b0,
        REG_SET_TOP_BIT = 1'b1
    } reg_idx_t;

    localparam logic [BYTES_W-1:0] BYTES_ONE   = 2'd1;
    localparam logic [BYTES_W-1:0] BYTES_TWO   = 2'd2;
    localparam logic [BYTES_W-1:0] BYTES_THREE = 2'd3;

    typedef struct packed {
        logic                 vld;
        logic                 last;
        logic [TAG_IDX_W-1:0] idx;
    } scan_tag_t;

endpackage

`default_nettype wire

// ===== src/pfcp_palette_ram.sv =====
// ----------------------------------------------------------------------------
// Palette memory
// One write port, one registered read port, 24-bit entries.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcp_palette_ram
    import pfcp_pkg::*;
#(
    parameter int DEPTH  = PALETTE_ENTRIES_DEF,
    parameter int ADDR_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [PIX_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/pfcp_dist_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted distance unit
// Four-stage pipeline: abs difference, square, weight, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcp_dist_unit
    import pfcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_tag_t         tag_in,
    input  wire logic [PIX_W-1:0]  entry,
    input  wire logic [CH_W-1:0]   pix_r,
    input  wire logic [CH_W-1:0]   pix_g,
    input  wire logic [CH_W-1:0]   pix_b,
    output      scan_tag_t         tag_out,
    output      logic [DIST_W-1:0] dist_sum
);

    scan_tag_t         tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [CH_W-1:0]   dr_reg, dg_reg, db_reg;
    logic [SQ_W-1:0]   sr_reg, sg_reg, sb_reg;
    logic [DIST_W-1:0] wr_reg, wg_reg, wb_reg;
    logic [DIST_W-1:0] sum_reg;
    logic [CH_W-1:0]   er, eg, eb;

    assign er = entry[23:16];
    assign eg = entry[15:8];
    assign eb = entry[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg  <= (pix_r > er) ? (pix_r - er) : (er - pix_r);
        dg_reg  <= (pix_g > eg) ? (pix_g - eg) : (eg - pix_g);
        db_reg  <= (pix_b > eb) ? (pix_b - eb) : (eb - pix_b);
        sr_reg  <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sg_reg  <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sb_reg  <= SQ_W'(db_reg) * SQ_W'(db_reg);
        wr_reg  <= DIST_W'(sr_reg) * W_RED;
        wg_reg  <= DIST_W'(sg_reg) * W_GREEN;
        wb_reg  <= DIST_W'(sb_reg) * W_BLUE;
        sum_reg <= wr_reg + wg_reg + wb_reg;
    end

    assign tag_out  = tag4_reg;
    assign dist_sum = sum_reg;

endmodule

`default_nettype wire

// ===== src/pfcp_format.sv =====
// ----------------------------------------------------------------------------
// Direct format packer
// Packs one pixel for every mode that needs no palette search.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcp_format
    import pfcp_pkg::*;
(
    input  wire logic [2:0]         mode,
    input  wire logic               set_top,
    input  wire logic [CH_W-1:0]    r,
    input  wire logic [CH_W-1:0]    g,
    input  wire logic [CH_W-1:0]    b,
    output      logic [PIX_W-1:0]   value,
    output      logic [BYTES_W-1:0] bytes
);

    always_comb
    begin
        value = '0;
        bytes = BYTES_TWO;
        unique case (mode)
            MODE_X1B5G5R5:
            begin
                value = {8'd0, 1'b0, b[7:3], g[7:3], r[7:3]};
                if (set_top)
                begin
                    value = value | TOP_BIT;
                end
            end
            MODE_RED:
            begin
                value = {16'd0, r};
                bytes = BYTES_ONE;
            end
            MODE_B2G3R3:
            begin
                value = {16'd0, b[7:6], g[7:5], r[7:5]};
                bytes = BYTES_ONE;
            end
            MODE_RGB24:
            begin
                value = {r, g, b};
                bytes = BYTES_THREE;
            end
            MODE_PALETTE:
            begin
                value = '0;
                bytes = BYTES_ONE;
            end
            default:
            begin
                value = {8'd0, r[7:3], g[7:3], b[7:3], 1'b0};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pixel_format_converter_palette.sv =====
// Direct modes: a result is registered in the cycle after its beat. Palette mode
// makes one memory read per entry, which feeds the four-stage distance pipeline;
// the nearest index is registered after the last entry leaves the pipeline.
// Throughput: one direct beat per cycle while the result is not stalled; the input
// is not ready during a palette search, so a palette beat holds off the next beat.
// Reset clears the mode registers and control; palette contents are undefined until written.
// ----------------------------------------------------------------------------
// Pixel format converter with palette search
// Converts RGB888 beats to several packed formats or to a nearest-color index.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter_palette
    import pfcp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // red, green, blue, entry_index
    input  wire logic                  s_tuser,   // op
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata    // pixel_value, byte_count
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [CH_W:0]    DEPTH_V  = (CH_W+1)'(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         mode_reg;
    logic               top_reg;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               issue_reg, issue_next;
    scan_tag_t          rd_tag_reg;
    logic [CH_W-1:0]    pr_reg, pg_reg, pb_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [TAG_IDX_W-1:0] best_idx_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_value_reg, out_value_next;
    logic [BYTES_W-1:0] out_bytes_reg, out_bytes_next;

    logic [CH_W-1:0]    in_r, in_g, in_b, in_idx;
    logic               in_acc, in_write, in_range;
    logic [PIX_W-1:0]   fmt_value, ram_q;
    logic [BYTES_W-1:0] fmt_bytes;
    scan_tag_t          d_tag;
    logic [DIST_W-1:0]  d_dist;
    logic               take;
    logic [TAG_IDX_W-1:0] take_idx;

    assign in_r     = s_tdata[7:0];
    assign in_g     = s_tdata[15:8];
    assign in_b     = s_tdata[23:16];
    assign in_idx   = s_tdata[31:24];
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign in_write = in_acc && (s_tuser == OP_WRITE);
    assign in_range = {1'b0, in_idx} < DEPTH_V;

    pfcp_format u_format (
        .mode    (mode_reg),
        .set_top (top_reg),
        .r       (in_r),
        .g       (in_g),
        .b       (in_b),
        .value   (fmt_value),
        .bytes   (fmt_bytes)
    );

    pfcp_palette_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (in_write && in_range),
        .wr_addr (in_idx[IDX_W-1:0]),
        .wr_data ({in_r, in_g, in_b}),
        .rd_en   (issue_reg),
        .rd_addr (cnt_reg),
        .rd_data (ram_q)
    );

    pfcp_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (rd_tag_reg),
        .entry    (ram_q),
        .pix_r    (pr_reg),
        .pix_g    (pg_reg),
        .pix_b    (pb_reg),
        .tag_out  (d_tag),
        .dist_sum (d_dist)
    );

    assign take     = (d_tag.idx == '0) || (d_dist < best_reg);
    assign take_idx = take ? d_tag.idx : best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_bytes_next = out_bytes_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_tuser == OP_CONVERT))
                begin
                    if (mode_reg == MODE_PALETTE)
                    begin
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                        issue_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = fmt_value;
                        out_bytes_next = fmt_bytes;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (d_tag.vld && d_tag.last)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_value_next = PIX_W'(take_idx);
                    out_bytes_next = BYTES_ONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_R5G5B5X1;
            top_reg       <= 1'b0;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            rd_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
            rd_tag_reg    <= '{vld: issue_reg, last: (cnt_reg == LAST_IDX),
                               idx: TAG_IDX_W'(cnt_reg)};
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_OUTPUT_MODE: mode_reg <= cfg_data;
                    REG_SET_TOP_BIT: top_reg  <= cfg_data[0];
                    default:         mode_reg <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_bytes_reg <= out_bytes_next;
        if (in_acc)
        begin
            pr_reg <= in_r;
            pg_reg <= in_g;
            pb_reg <= in_b;
        end
        if (d_tag.vld)
        begin
            best_idx_reg <= take_idx;
            if (take)
            begin
                best_reg <= d_dist;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - PIX_W - BYTES_W)'(0), out_bytes_reg, out_value_reg};

endmodule

`default_nettype wire

// ===== src/pfcp_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel format converter port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_format_converter_palette_defines.svh"

module pfcp_checker
    import pfcp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata
);

    `PFCP_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `PFCP_ASSERT_IMP(a_bytes_nonzero, clk, rst_n, m_tvalid, m_tdata[25:24] != 2'd0, "byte count is zero")
    `PFCP_ASSERT_IMP(a_one_byte, clk, rst_n, m_tvalid && (m_tdata[25:24] == BYTES_ONE), m_tdata[23:8] == 16'd0, "one-byte result has high bits set")
    `PFCP_ASSERT_IMP(a_two_byte, clk, rst_n, m_tvalid && (m_tdata[25:24] == BYTES_TWO), m_tdata[23:16] == 8'd0, "two-byte result has high bits set")
    `PFCP_ASSERT_IMP(a_no_accept_full, clk, rst_n, m_tvalid && !m_tready, !s_tready, "input ready while result stalled")

endmodule

bind pixel_format_converter_palette pfcp_checker u_pfcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel format converter regression
// Directed table of corner pixels in every direct output mode, then random phases
// over all mode and top-bit settings with a full palette, checked beat by
// beat against an in-bench predictor under varied source and sink idling.
// ----------------------------------------------------------------------------
module testbench;
    import pfcp_pkg::*;

    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam int DIR_ROWS       = 23;
    localparam int NUM_PHASES     = 16;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = PALETTE_ENTRIES_DEF + 40;
    localparam int TIMEOUT_NS     = 20_000_000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_value;
        logic [BYTES_W-1:0] byte_count;
    } pix_result_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic               top;
        op_t                op;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         entry_index;
        bit                 typed;
        logic [PIX_W-1:0]   pixel_value;
        logic [BYTES_W-1:0] byte_count;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // red, green, blue, entry_index
    logic                  s_tuser = 1'b0; // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // pixel_value, byte_count

    logic [2:0]   cur_mode = MODE_R5G5B5X1;
    logic         cur_top = 1'b0;
    logic [23:0]  palette_model [PALETTE_ENTRIES_DEF];
    pix_result_t  expected_pixels [$];
    int           fail_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_cycles_req = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{MODE_R5G5B5X1, 1'b0, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'h00fffe, BYTES_TWO},
        '{MODE_R5G5B5X1, 1'b0, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 24'h000000, BYTES_TWO},
        '{MODE_R5G5B5X1, 1'b0, OP_CONVERT, 8'h12, 8'ha7, 8'h5c, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_R5G5B5X1, 1'b0, OP_WRITE,   8'h11, 8'h22, 8'h33, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_X1B5G5R5, 1'b0, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'h007fff, BYTES_TWO},
        '{MODE_X1B5G5R5, 1'b0, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000, BYTES_TWO},
        '{MODE_X1B5G5R5, 1'b1, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h008000, BYTES_TWO},
        '{MODE_X1B5G5R5, 1'b1, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'h00ffff, BYTES_TWO},
        '{MODE_X1B5G5R5, 1'b1, OP_CONVERT, 8'h80, 8'h40, 8'hc8, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_X1B5G5R5, 1'b1, OP_WRITE,   8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 24'h0, 2'd0},
        '{MODE_RED,      1'b0, OP_CONVERT, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 24'h0000ff, BYTES_ONE},
        '{MODE_RED,      1'b0, OP_CONVERT, 8'h00, 8'hff, 8'hff, 8'h00, 1'b1, 24'h000000, BYTES_ONE},
        '{MODE_RED,      1'b0, OP_CONVERT, 8'h5a, 8'h3c, 8'hc3, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_B2G3R3,   1'b0, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'h0000ff, BYTES_ONE},
        '{MODE_B2G3R3,   1'b0, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000, BYTES_ONE},
        '{MODE_B2G3R3,   1'b0, OP_CONVERT, 8'h9b, 8'h6e, 8'h47, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_RGB24,    1'b0, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'hffffff, BYTES_THREE},
        '{MODE_RGB24,    1'b0, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000, BYTES_THREE},
        '{MODE_RGB24,    1'b0, OP_CONVERT, 8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 24'h123456, BYTES_THREE},
        '{MODE_RGB24,    1'b0, OP_WRITE,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h0, 2'd0},
        '{MODE_UNDEF_LO, 1'b0, OP_CONVERT, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'h00fffe, BYTES_TWO},
        '{MODE_UNDEF_HI, 1'b0, OP_CONVERT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000, BYTES_TWO},
        '{MODE_UNDEF_HI, 1'b0, OP_CONVERT, 8'h9d, 8'he2, 8'h31, 8'h00, 1'b0, 24'h0, 2'd0}
    };

    logic [2:0] phase_mode [NUM_PHASES] = '{
        MODE_RGB24, MODE_R5G5B5X1, MODE_X1B5G5R5, MODE_PALETTE,
        MODE_RED, MODE_B2G3R3, MODE_X1B5G5R5, MODE_PALETTE,
        MODE_UNDEF_LO, MODE_R5G5B5X1, MODE_PALETTE, MODE_UNDEF_HI,
        MODE_PALETTE, MODE_RGB24, MODE_B2G3R3, MODE_X1B5G5R5
    };
    logic phase_top [NUM_PHASES] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1
    };

    pixel_format_converter_palette u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("pixel_format_converter_palette regression: fail");
        $finish;
    end

    function automatic logic [7:0] nearest_palette_index(logic [7:0] r, logic [7:0] g,
                                                         logic [7:0] b);
        int unsigned best_dist;
        int unsigned cand_dist;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        logic [23:0] e;
        logic [7:0]  best_idx;
        best_dist = 32'hffff_ffff;
        best_idx  = 8'd0;
        for (int i = 0; i < PALETTE_ENTRIES_DEF; i++)
        begin
            e  = palette_model[i];
            dr = (r > e[23:16]) ? r - e[23:16] : e[23:16] - r;
            dg = (g > e[15:8])  ? g - e[15:8]  : e[15:8] - g;
            db = (b > e[7:0])   ? b - e[7:0]   : e[7:0] - b;
            cand_dist = W_RED * dr * dr + W_GREEN * dg * dg + W_BLUE * db * db;
            if (cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best_idx  = i[7:0];
            end
        end
        return best_idx;
    endfunction

    function automatic pix_result_t predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pix_result_t res;
        case (cur_mode)
            MODE_X1B5G5R5:
            begin
                res.pixel_value = {8'h00, cur_top, b[7:3], g[7:3], r[7:3]};
                res.byte_count  = BYTES_TWO;
            end
            MODE_RED:
            begin
                res.pixel_value = {16'h0000, r};
                res.byte_count  = BYTES_ONE;
            end
            MODE_B2G3R3:
            begin
                res.pixel_value = {16'h0000, b[7:6], g[7:5], r[7:5]};
                res.byte_count  = BYTES_ONE;
            end
            MODE_RGB24:
            begin
                res.pixel_value = {r, g, b};
                res.byte_count  = BYTES_THREE;
            end
            MODE_PALETTE:
            begin
                res.pixel_value = {16'h0000, nearest_palette_index(r, g, b)};
                res.byte_count  = BYTES_ONE;
            end
            default:
            begin
                res.pixel_value = {8'h00, r[7:3], g[7:3], b[7:3], 1'b0};
                res.byte_count  = BYTES_TWO;
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] random_channel();
        if ($urandom_range(99) < 10)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // near an existing entry in 45 percent of palette-mode pixels, to hit ties
    function automatic logic [23:0] random_pixel();
        logic [23:0] e;
        if (cur_mode == MODE_PALETTE && $urandom_range(99) < 45)
        begin
            e = palette_model[$urandom_range(PALETTE_ENTRIES_DEF - 1)];
            if ($urandom_range(1))
                return e;
            return {nudge(e[23:16]), nudge(e[15:8]), nudge(e[7:0])};
        end
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // copy an already written entry now and then so that duplicates exist
    function automatic logic [23:0] random_entry_color(int written);
        if (written > 0 && $urandom_range(99) < 30)
            return palette_model[$urandom_range(written - 1)];
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    task automatic send_beat(op_t op, logic [23:0] rgb, logic [7:0] idx, bit typed,
                             pix_result_t typed_res);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {idx, rgb[7:0], rgb[15:8], rgb[23:16]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_WRITE)
            palette_model[idx] = rgb;
        else if (typed)
            expected_pixels.push_back(typed_res);
        else
            expected_pixels.push_back(predict_pixel(rgb[23:16], rgb[15:8], rgb[7:0]));
    endtask

    task automatic wait_until_idle(int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_config(logic [2:0] mode, logic top);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OUTPUT_MODE;
        cfg_data  <= mode;
        @(posedge clk);
        cfg_index <= REG_SET_TOP_BIT;
        cfg_data  <= {2'b00, top};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_mode = mode;
        cur_top  = top;
    endtask

    initial
    begin
        int n;
        int k4;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
            begin
                k4 = $urandom_range(99);
                m_tready <= (k4 >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        pix_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_value: expected none, actual %h", m_tdata[PIX_W-1:0]);
                fail_cnt++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata[PIX_W-1:0] !== want.pixel_value)
                begin
                    $error("pixel_value: expected %h, actual %h", want.pixel_value,
                           m_tdata[PIX_W-1:0]);
                    fail_cnt++;
                end
                if (m_tdata[PIX_W+BYTES_W-1:PIX_W] !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, actual %0d", want.byte_count,
                           m_tdata[PIX_W+BYTES_W-1:PIX_W]);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        logic [23:0] px;
        pix_result_t row_res;
        int          n;
        int          idle_kind;
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != cur_mode || dir_tab[i].top != cur_top)
            begin
                wait_until_idle(DRAIN_CYCLES);
                write_config(dir_tab[i].mode, dir_tab[i].top);
            end
            row_res.pixel_value = dir_tab[i].pixel_value;
            row_res.byte_count  = dir_tab[i].byte_count;
            send_beat(dir_tab[i].op, {dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue},
                      dir_tab[i].entry_index, dir_tab[i].typed, row_res);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_idle(DRAIN_CYCLES);
            write_config(phase_mode[p], phase_top[p]);
            idle_kind    = p % 4;
            tx_idle_pct  = (idle_kind == 1) ? 85 : (idle_kind == 3) ? 13 : 0;
            rx_stall_pct = (idle_kind == 2) ? 85 : (idle_kind == 3) ? 13 : 0;
            if (p == 0)
            begin
                // fill every entry before any palette search
                for (int k = 0; k < PALETTE_ENTRIES_DEF; k++)
                begin
                    if ($urandom_range(99) < 15)
                        send_beat(OP_CONVERT, random_pixel(), 8'($urandom_range(255)), 1'b0,
                                  '0);
                    send_beat(OP_WRITE, random_entry_color(k), k[7:0], 1'b0, '0);
                end
            end
            else
            begin
                n = (phase_mode[p] == MODE_PALETTE) ? 50 : 130;
                if (p == PRESSURE_PHASE)
                    hold_cycles_req = LONG_HOLD;
                for (int k = 0; k < n; k++)
                begin
                    if (p == PRESSURE_PHASE && k == n / 2)
                        wait_until_idle(0);
                    if ($urandom_range(99) < 15)
                    begin
                        px = random_entry_color(PALETTE_ENTRIES_DEF);
                        send_beat(OP_WRITE, px, 8'($urandom_range(255)), 1'b0, '0);
                    end
                    else
                        send_beat(OP_CONVERT, random_pixel(), 8'($urandom_range(255)), 1'b0,
                                  '0);
                end
            end
        end

        s_tvalid <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("pixel_format_converter_palette regression: pass");
        else
            $display("pixel_format_converter_palette regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pfcp_pkg.sv
src/pfcp_palette_ram.sv
src/pfcp_dist_unit.sv
src/pfcp_format.sv
src/pixel_format_converter_palette.sv
src/pfcp_checker.sv
sim/testbench.sv
